FILE: design/dvrt_pkg.sv
// Package for the distance-vector route table.
// Holds the payload structs, the mode and state codes and the store port structs.
// No dependencies.
package dvrt_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned COST_W = 16;
  localparam int unsigned LIFE_W = 8;
  localparam int unsigned MAX_NODES = 2 ** NODE_W;

  localparam logic [COST_W-1:0] UNREACHABLE = 16'hffff;
  localparam logic [LIFE_W-1:0] LIFETIME_RST = 8'd45;

  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] REG_LIFETIME = 2'd0;

  typedef logic [NODE_W-1:0] dvrt_node_t;

  typedef enum logic [1:0] {
    MODE_LINK   = 2'd0,
    MODE_AGE    = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_LOOKUP = 2'd3
  } dvrt_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DECIDE,
    ST_SCAN,
    ST_DONE
  } dvrt_state_t;

  typedef struct packed {
    dvrt_mode_t        mode;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] hop_id;
    logic [COST_W-1:0] old_cost;
    logic [COST_W-1:0] new_cost;
  } dvrt_in_t;

  typedef struct packed {
    logic              changed;
    logic              route_present;
    logic [NODE_W-1:0] route_hop;
    logic [COST_W-1:0] route_metric;
  } dvrt_out_t;

  typedef struct packed {
    logic              route_we;
    logic [NODE_W-1:0] route_addr;
    logic [COST_W-1:0] cost;
    logic [NODE_W-1:0] next;
    logic [LIFE_W-1:0] life;
    logic              valid_we;
    logic              valid_val;
    logic              link_we;
    logic [NODE_W-1:0] link_addr;
    logic              link_val;
    logic [COST_W-1:0] link_cost;
  } dvrt_wr_t;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] next;
    logic [COST_W-1:0] cost;
    logic [LIFE_W-1:0] life;
    logic              link_up;
    logic [COST_W-1:0] link_cost;
  } dvrt_rd_t;

endpackage

FILE: design/dvrt_store.sv
// Route and link storage for the distance-vector route table.
// Memories with one write and one registered read port, plus valid and link-up flags.
// Depends on dvrt_pkg.
module dvrt_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dvrt_pkg::dvrt_wr_t           wr,
  input  logic [dvrt_pkg::NODE_W-1:0]  rd_addr,
  output dvrt_pkg::dvrt_rd_t           rd
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [dvrt_pkg::COST_W-1:0] cost_mem_r [DEPTH];
  logic [dvrt_pkg::NODE_W-1:0] next_mem_r [DEPTH];
  logic [dvrt_pkg::LIFE_W-1:0] life_mem_r [DEPTH];
  logic [dvrt_pkg::COST_W-1:0] link_mem_r [DEPTH];
  logic [DEPTH-1:0]            valid_r;
  logic [DEPTH-1:0]            up_r;
  dvrt_pkg::dvrt_rd_t          rd_r;

  logic [IW-1:0] wa;
  logic [IW-1:0] la;
  logic [IW-1:0] ra;

  assign wa = wr.route_addr[IW-1:0];
  assign la = wr.link_addr[IW-1:0];
  assign ra = rd_addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (wr.route_we) begin
      cost_mem_r[wa] <= wr.cost;
      next_mem_r[wa] <= wr.next;
      life_mem_r[wa] <= wr.life;
    end
    if (wr.link_we) begin
      link_mem_r[la] <= wr.link_cost;
    end
    rd_r.cost      <= cost_mem_r[ra];
    rd_r.next      <= next_mem_r[ra];
    rd_r.life      <= life_mem_r[ra];
    rd_r.link_cost <= link_mem_r[ra];
    rd_r.valid     <= valid_r[ra];
    rd_r.link_up   <= up_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      up_r    <= '0;
    end else begin
      if (wr.valid_we) begin
        valid_r[wa] <= wr.valid_val;
      end
      if (wr.link_we) begin
        up_r[la] <= wr.link_val;
      end
    end
  end

  assign rd = rd_r;

endmodule

FILE: design/dvrt_seq.sv
// Sequencer and shared entry update unit for the distance-vector route table.
// Walks the store one entry per cycle for link changes and aging ticks.
// Depends on dvrt_pkg.
module dvrt_seq #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dvrt_pkg::dvrt_in_t           in_data,
  input  logic [dvrt_pkg::LIFE_W-1:0]  lifetime,
  output logic [dvrt_pkg::NODE_W-1:0]  rd_addr,
  input  dvrt_pkg::dvrt_rd_t           rd,
  output dvrt_pkg::dvrt_wr_t           wr,
  output logic                         res_valid,
  input  logic                         res_ready,
  output dvrt_pkg::dvrt_out_t          res
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_END = CW'(DEPTH);

  dvrt_pkg::dvrt_state_t state_r, state_nxt;
  dvrt_pkg::dvrt_in_t    item_r, item_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;
  dvrt_pkg::dvrt_node_t  pa_r, pa_nxt;
  logic                  chg_r, chg_nxt;
  dvrt_pkg::dvrt_out_t   res_r, res_nxt;

  logic                        in_range;
  logic                        drop_all;
  logic [dvrt_pkg::COST_W-1:0] delta;

  assign in_range = (32'(item_r.node_id) < DEPTH);
  assign drop_all = (item_r.new_cost == dvrt_pkg::UNREACHABLE);
  assign delta    = item_r.new_cost - item_r.old_cost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dvrt_pkg::ST_IDLE;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    cnt_r  <= cnt_nxt;
    pa_r   <= pa_nxt;
    chg_r  <= chg_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    cnt_nxt   = cnt_r;
    pv_nxt    = 1'b0;
    pa_nxt    = pa_r;
    chg_nxt   = chg_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    rd_addr   = item_r.node_id;
    wr        = '0;
    res       = res_r;

    unique case (state_r)
      dvrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = dvrt_pkg::ST_LOOK;
        end
      end

      dvrt_pkg::ST_LOOK: begin
        if (item_r.mode == dvrt_pkg::MODE_LINK && in_range) begin
          wr.link_we   = 1'b1;
          wr.link_addr = item_r.node_id;
          wr.link_val  = !drop_all;
          wr.link_cost = item_r.new_cost;
        end
        res_nxt   = '0;
        chg_nxt   = 1'b0;
        cnt_nxt   = '0;
        state_nxt = dvrt_pkg::ST_DECIDE;
      end

      dvrt_pkg::ST_DECIDE: begin
        state_nxt     = dvrt_pkg::ST_DONE;
        wr.route_addr = item_r.node_id;
        wr.cost       = item_r.new_cost;
        wr.life       = lifetime;
        wr.valid_val  = 1'b1;
        case (item_r.mode)
          dvrt_pkg::MODE_LINK: begin
            if (in_range) begin
              if (!rd.valid) begin
                chg_nxt = 1'b1;
                if (!drop_all) begin
                  wr.route_we = 1'b1;
                  wr.valid_we = 1'b1;
                  wr.next     = item_r.node_id;
                end
              end else if (item_r.old_cost != item_r.new_cost) begin
                state_nxt = dvrt_pkg::ST_SCAN;
              end
            end
          end
          dvrt_pkg::MODE_AGE: begin
            state_nxt = dvrt_pkg::ST_SCAN;
          end
          dvrt_pkg::MODE_WRITE: begin
            if (in_range) begin
              chg_nxt     = 1'b1;
              wr.route_we = 1'b1;
              wr.valid_we = 1'b1;
              wr.next     = item_r.hop_id;
            end
          end
          default: begin
            if (in_range && rd.valid) begin
              res_nxt.route_present = 1'b1;
              res_nxt.route_hop     = rd.next;
              res_nxt.route_metric  = rd.cost;
            end
          end
        endcase
      end

      dvrt_pkg::ST_SCAN: begin
        if (cnt_r < CNT_END) begin
          rd_addr = dvrt_pkg::dvrt_node_t'(cnt_r);
          pv_nxt  = 1'b1;
          pa_nxt  = dvrt_pkg::dvrt_node_t'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          state_nxt = dvrt_pkg::ST_DONE;
        end
        if (pv_r) begin
          wr.route_addr = pa_r;
          wr.cost       = rd.cost;
          wr.next       = rd.next;
          wr.life       = lifetime;
          if (item_r.mode == dvrt_pkg::MODE_AGE) begin
            if (rd.valid) begin
              wr.route_we = 1'b1;
              wr.life     = rd.life - 1'b1;
              if (rd.life == 8'd1) begin
                wr.valid_we  = 1'b1;
                wr.valid_val = 1'b0;
                chg_nxt      = 1'b1;
              end
            end
          end else if (rd.valid && rd.next == item_r.node_id) begin
            chg_nxt = 1'b1;
            if (drop_all) begin
              wr.valid_we  = 1'b1;
              wr.valid_val = rd.link_up;
              wr.route_we  = rd.link_up;
              wr.cost      = rd.link_cost;
              wr.next      = pa_r;
            end else begin
              wr.route_we = 1'b1;
              wr.cost     = rd.cost + delta;
            end
          end
        end
      end

      dvrt_pkg::ST_DONE: begin
        res_valid   = 1'b1;
        res.changed = chg_r;
        if (res_ready) begin
          state_nxt = dvrt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dvrt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/distance_vector_route_table.sv
// Top level of the distance-vector route table: APB register, sequencer, store, output register.
// Depends on dvrt_pkg, dvrt_store and dvrt_seq.
//
//   Channel   Ports                                   Transfer
//   input     in_valid, in_ready, in_data             in_valid and in_ready high at a clock edge
//   result    out_valid, out_ready, out_data          out_valid and out_ready high at a clock edge
//   config    psel, penable, pwrite, paddr, pwdata    psel, penable, pwrite and pready high
//
// Lookups, route writes and link changes that need no walk pass through the LOOK, DECIDE
// and DONE states and then the output register. Link changes that touch existing routes and
// aging ticks walk every entry through the single read port of the route memory, one per cycle.
// Reset is synchronous and clears the valid and link-up flags at once; no clearing pass.
// A waiting result sits in the output register while the next transfer is accepted.
module distance_vector_route_table #(
  parameter int unsigned NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dvrt_pkg::dvrt_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dvrt_pkg::dvrt_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dvrt_pkg::APB_AW-1:0]   paddr,
  input  logic [dvrt_pkg::APB_DW-1:0]   pwdata,
  output logic [dvrt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned DEPTH = (NODES < dvrt_pkg::MAX_NODES) ? NODES : dvrt_pkg::MAX_NODES;

  logic [dvrt_pkg::LIFE_W-1:0] lifetime_r;
  logic                        out_valid_r;
  dvrt_pkg::dvrt_out_t         out_data_r;

  dvrt_pkg::dvrt_wr_t          wr;
  dvrt_pkg::dvrt_rd_t          rd;
  logic [dvrt_pkg::NODE_W-1:0] rd_addr;
  logic                        res_valid;
  logic                        res_ready;
  dvrt_pkg::dvrt_out_t         res;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == dvrt_pkg::REG_LIFETIME);
  assign prdata    = (paddr == dvrt_pkg::REG_LIFETIME) ?
                     dvrt_pkg::APB_DW'(lifetime_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= dvrt_pkg::LIFETIME_RST;
    end else if (cfg_write) begin
      lifetime_r <= pwdata[dvrt_pkg::LIFE_W-1:0];
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dvrt_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .lifetime (lifetime_r),
    .rd_addr  (rd_addr),
    .rd       (rd),
    .wr       (wr),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  dvrt_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_addr(rd_addr),
    .rd     (rd)
  );

endmodule

FILE: design/dvrt_checker.sv
// Port-level checks for the distance-vector route table, bound to the top level.
// Depends on dvrt_pkg and distance_vector_route_table.
module dvrt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dvrt_pkg::dvrt_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed while stalled.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input ready right after a transfer.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_lookup_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.route_present |-> !out_data.changed)
    else $error("Lookup result reports a table change.");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.route_present |->
      out_data.route_hop == '0 && out_data.route_metric == '0)
    else $error("Absent route carries hop or metric.");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);

FILE: bench/dvrt_checker.sv
// Checker for the distance-vector route table: watches the input, result and register ports.
// Keeps its own copy of the route and link tables and compares every result transfer.
// Depends on dvrt_pkg.
module tb_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  dvrt_pkg::dvrt_in_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  dvrt_pkg::dvrt_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [dvrt_pkg::APB_AW-1:0] paddr,
  input  logic [dvrt_pkg::APB_DW-1:0] pwdata,
  output int unsigned                 errors,
  output int unsigned                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dvrt_pkg::*;

  logic              route_ok    [MAX_NODES];
  dvrt_node_t        hop_of      [MAX_NODES];
  logic [COST_W-1:0] cost_of     [MAX_NODES];
  logic [LIFE_W-1:0] life_of     [MAX_NODES];
  logic              link_live   [MAX_NODES];
  logic [COST_W-1:0] link_metric [MAX_NODES];
  logic [LIFE_W-1:0] lifetime;
  dvrt_out_t         answer_q [$];

  function automatic void install(dvrt_node_t d, logic [COST_W-1:0] c, dvrt_node_t h);
    route_ok[d] = 1'b1;
    cost_of[d]  = c;
    hop_of[d]   = h;
    life_of[d]  = lifetime;
  endfunction

  function automatic dvrt_out_t table_update(dvrt_in_t ev);
    dvrt_out_t         res;
    logic [COST_W-1:0] delta;
    logic              dropped [MAX_NODES];
    res = '0;
    case (ev.mode)
      MODE_LINK: begin
        link_live[ev.node_id]   = (ev.new_cost != UNREACHABLE);
        link_metric[ev.node_id] = ev.new_cost;
        if (!route_ok[ev.node_id]) begin
          if (ev.new_cost != UNREACHABLE) begin
            install(ev.node_id, ev.new_cost, ev.node_id);
          end
          res.changed = 1'b1;
        end else if (ev.old_cost != ev.new_cost) begin
          delta = ev.new_cost - ev.old_cost;
          for (int d = 0; d < MAX_NODES; d++) begin
            dropped[d] = 1'b0;
            if (route_ok[d] && hop_of[d] == ev.node_id) begin
              res.changed = 1'b1;
              if (ev.new_cost == UNREACHABLE) begin
                route_ok[d] = 1'b0;
                dropped[d]  = 1'b1;
              end else begin
                cost_of[d] = cost_of[d] + delta;
                life_of[d] = lifetime;
              end
            end
          end
          for (int d = 0; d < MAX_NODES; d++) begin
            if (dropped[d] && link_live[d]) begin
              install(dvrt_node_t'(d), link_metric[d], dvrt_node_t'(d));
            end
          end
        end
      end
      MODE_AGE: begin
        for (int d = 0; d < MAX_NODES; d++) begin
          if (route_ok[d]) begin
            life_of[d] = life_of[d] - 1'b1;
            if (life_of[d] == '0) begin
              route_ok[d] = 1'b0;
              res.changed = 1'b1;
            end
          end
        end
      end
      MODE_WRITE: begin
        install(ev.node_id, ev.new_cost, ev.hop_id);
        res.changed = 1'b1;
      end
      default: begin
        if (route_ok[ev.node_id]) begin
          res.route_present = 1'b1;
          res.route_hop     = hop_of[ev.node_id];
          res.route_metric  = cost_of[ev.node_id];
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    dvrt_out_t want;
    if (!rst_n) begin
      lifetime = LIFETIME_RST;
      for (int d = 0; d < MAX_NODES; d++) begin
        route_ok[d]  = 1'b0;
        link_live[d] = 1'b0;
      end
      answer_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_LIFETIME) begin
        lifetime = pwdata[LIFE_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t unexpected result: changed=%0b present=%0b hop=%0d metric=%04h",
                   $time, out_data.changed, out_data.route_present, out_data.route_hop,
                   out_data.route_metric);
          errors <= errors + 1;
        end else begin
          want = answer_q.pop_front();
          if (out_data !== want) begin
            $display({"%0t result mismatch: expected changed=%0b present=%0b hop=%0d ",
                      "metric=%04h, actual changed=%0b present=%0b hop=%0d metric=%04h"},
                     $time, want.changed, want.route_present, want.route_hop,
                     want.route_metric, out_data.changed, out_data.route_present,
                     out_data.route_hop, out_data.route_metric);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        answer_q.push_back(table_update(in_data));
      end
      pending <= unsigned'(answer_q.size());
    end
  end

endmodule

FILE: bench/tb_top.sv
// Top of the route table testbench: clock, reset, stimulus, register writes and verdict.
// Depends on dvrt_pkg, distance_vector_route_table and tb_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dvrt_pkg::*;

  localparam int unsigned PHASE_ITEMS  = 135;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  dvrt_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  dvrt_out_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned errors;
  int unsigned pending;
  int unsigned gap_max      = 0;
  int unsigned stall_max    = 0;
  int unsigned out_hold     = 0;
  int unsigned quiet_cycles = 0;

  dvrt_node_t        hot_ids [6];
  logic [LIFE_W-1:0] lifetimes [6] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd128, LIFETIME_RST};

  always #2 clk = ~clk;

  distance_vector_route_table dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  tb_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .pending
  );

  always @(posedge clk) begin : rx_side
    int unsigned draw;
    if (!rst_n) begin
      out_hold  <= 0;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      draw = $urandom_range(0, stall_max);
      out_hold  <= draw;
      out_ready <= (draw == 0);
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic dvrt_in_t make_event(dvrt_mode_t m, dvrt_node_t n, dvrt_node_t h,
                                          logic [COST_W-1:0] oc, logic [COST_W-1:0] nc);
    dvrt_in_t ev;
    ev.mode     = m;
    ev.node_id  = n;
    ev.hop_id   = h;
    ev.old_cost = oc;
    ev.new_cost = nc;
    return ev;
  endfunction

  function automatic dvrt_node_t pick_node();
    if ($urandom_range(0, 9) < 7) begin
      return hot_ids[$urandom_range(0, 5)];
    end
    return dvrt_node_t'($urandom_range(0, MAX_NODES - 1));
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 3))
      0:       return COST_W'($urandom_range(0, 65535));
      1:       return UNREACHABLE - COST_W'($urandom_range(0, 3));
      default: return COST_W'($urandom_range(0, 300));
    endcase
  endfunction

  function automatic dvrt_in_t random_event();
    dvrt_in_t    ev;
    int unsigned r;
    r = $urandom_range(0, 19);
    ev = make_event(MODE_LOOKUP, pick_node(), pick_node(), pick_cost(), pick_cost());
    if (r < 6) begin
      ev.mode = MODE_LINK;
      r = $urandom_range(0, 9);
      if (r < 2) begin
        ev.new_cost = UNREACHABLE;
      end else if (r < 4) begin
        ev.new_cost = ev.old_cost;
      end
    end else if (r < 9) begin
      ev.mode = MODE_AGE;
    end else if (r < 15) begin
      ev.mode = MODE_WRITE;
    end
    return ev;
  endfunction

  task automatic push_item(dvrt_in_t item);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_lifetime(logic [LIFE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_LIFETIME;
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    lifetimes[4] = LIFE_W'($urandom_range(2, 254));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    push_item(make_event(MODE_LOOKUP, 6'd0, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LINK, 6'd5, 6'd0, 16'h0000, UNREACHABLE));
    push_item(make_event(MODE_LINK, 6'd5, 6'd0, UNREACHABLE, 16'd10));
    push_item(make_event(MODE_WRITE, 6'd63, 6'd5, 16'h0000, UNREACHABLE));
    push_item(make_event(MODE_WRITE, 6'd20, 6'd5, 16'h0000, 16'd100));
    push_item(make_event(MODE_WRITE, 6'd0, 6'd63, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LOOKUP, 6'd63, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LOOKUP, 6'd20, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LOOKUP, 6'd0, 6'd63, UNREACHABLE, UNREACHABLE));
    push_item(make_event(MODE_LINK, 6'd5, 6'd0, 16'd10, 16'd10));
    push_item(make_event(MODE_LINK, 6'd5, 6'd0, 16'd10, 16'd3));
    push_item(make_event(MODE_LOOKUP, 6'd63, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LINK, 6'd20, 6'd0, 16'h0000, 16'd7));
    push_item(make_event(MODE_LINK, 6'd5, 6'd0, 16'd3, UNREACHABLE));
    push_item(make_event(MODE_LOOKUP, 6'd20, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_LOOKUP, 6'd5, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_AGE, 6'd63, 6'd63, UNREACHABLE, UNREACHABLE));
    push_item(make_event(MODE_LINK, 6'd63, 6'd0, 16'h0000, 16'd1));
    push_item(make_event(MODE_WRITE, 6'd40, 6'd63, 16'h0000, 16'habcd));
    push_item(make_event(MODE_LINK, 6'd63, 6'd0, 16'd1, 16'hfffe));
    push_item(make_event(MODE_LOOKUP, 6'd40, 6'd0, 16'h0000, 16'h0000));
    push_item(make_event(MODE_AGE, 6'd0, 6'd0, 16'h0000, 16'h0000));

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_lifetime(lifetimes[p]);
      for (int k = 0; k < 6; k++) begin
        hot_ids[k] = dvrt_node_t'($urandom_range(0, MAX_NODES - 1));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 45 == 0) begin
          gap_max   = $urandom_range(0, 1) ? 4 : 0;
          stall_max = $urandom_range(0, 1) ? 4 : 0;
        end
        push_item(random_event());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
